// ----- rtl/speq_pkg.sv -----
// ============================================================================
// speq_pkg
// Types, constants and arithmetic helpers for the stereo peaking EQ section.
// ============================================================================
`default_nettype none

package speq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int STATE_BITS  = 48;
    localparam int PCM_BITS    = 16;
    localparam int LANES       = 2;

    localparam int FS_BITS = SAMPLE_BITS - 4;
    localparam int FC_BITS = COEF_BITS - 4;
    localparam int FZ_BITS = FS_BITS + 8;
    localparam int SHX     = FC_BITS + FS_BITS - FZ_BITS;
    localparam int SHY     = FC_BITS;
    localparam int SHO     = FZ_BITS - FS_BITS;

    localparam int PX_BITS    = COEF_BITS + SAMPLE_BITS;
    localparam int YLO_BITS   = STATE_BITS / 2;
    localparam int YHI_BITS   = STATE_BITS - YLO_BITS;
    localparam int PHI_BITS   = COEF_BITS + YHI_BITS;
    localparam int PLO_BITS   = COEF_BITS + YLO_BITS + 1;
    localparam int PY_BITS    = COEF_BITS + STATE_BITS;
    localparam int WIDE_BITS  = 64;
    localparam int PP_BITS    = SAMPLE_BITS + PCM_BITS;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [STATE_BITS-1:0]  t_state;
    typedef logic signed [PCM_BITS-1:0]    t_pcm;
    typedef logic signed [PX_BITS-1:0]     t_px;
    typedef logic signed [PHI_BITS-1:0]    t_phi;
    typedef logic signed [PLO_BITS-1:0]    t_plo;
    typedef logic signed [PY_BITS-1:0]     t_py;
    typedef logic signed [WIDE_BITS-1:0]   t_wide;
    typedef logic signed [PP_BITS-1:0]     t_pp;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_B0     = 3'd0,
        CFG_B1     = 3'd1,
        CFG_B2     = 3'd2,
        CFG_A1     = 3'd3,
        CFG_A2     = 3'd4,
        CFG_BYPASS = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MX,
        SEQ_Y,
        SEQ_AY,
        SEQ_ACC,
        SEQ_COMMIT
    } t_seq_state;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
        logic  bypass;
    } t_coefs;

    typedef struct packed {
        logic load;
        logic mul_x;
        logic sum_y;
        logic mul_y;
        logic acc;
        logic commit;
    } t_lane_ctrl;

    typedef struct packed {
        t_sample sample;
        t_pcm    pcm;
        logic    clip;
    } t_lane_res;

    localparam t_coef   B0_RESET   = t_coef'(1) <<< FC_BITS;
    localparam t_wide   ST_MAX     = (t_wide'(1) <<< (STATE_BITS - 1)) - t_wide'(1);
    localparam t_wide   ST_MIN     = -ST_MAX - t_wide'(1);
    localparam t_state  LIM4       = t_state'(4) <<< FZ_BITS;
    localparam t_sample PCM_ONE    = t_sample'(1) <<< FS_BITS;
    localparam t_pcm    PCM_SCALE  = t_pcm'(32767);

    function automatic t_state f_sat(input t_wide v);
        t_state r;
        if (v > ST_MAX) begin
            r = t_state'(ST_MAX);
        end else if (v < ST_MIN) begin
            r = t_state'(ST_MIN);
        end else begin
            r = v[STATE_BITS-1:0];
        end
        return r;
    endfunction

    // Rounds to nearest with ties away from zero, then saturates.
    function automatic t_state f_round_px(input t_px p);
        t_px t;
        t = p + (t_px'(1) <<< (SHX - 1)) - t_px'({1'b0, p[PX_BITS-1]});
        return f_sat(t_wide'($signed(t[PX_BITS-1:SHX])));
    endfunction

    function automatic t_state f_round_py(input t_py p);
        t_py t;
        t = p + (t_py'(1) <<< (SHY - 1)) - t_py'({1'b0, p[PY_BITS-1]});
        return f_sat(t_wide'($signed(t[PY_BITS-1:SHY])));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/speq_stream_if.sv -----
// ============================================================================
// speq_stream_if
// Valid/ready channels for stereo frames in and filtered results out.
// ============================================================================
`default_nettype none

interface speq_frame_if;
    logic              valid;
    logic              ready;
    speq_pkg::t_sample left_in;
    speq_pkg::t_sample right_in;
    logic              last_in_block;

    modport source (output valid, left_in, right_in, last_in_block, input ready);
    modport sink   (input valid, left_in, right_in, last_in_block, output ready);
endinterface

interface speq_result_if;
    logic              valid;
    logic              ready;
    speq_pkg::t_sample left_out;
    speq_pkg::t_sample right_out;
    speq_pkg::t_pcm    pcm_left;
    speq_pkg::t_pcm    pcm_right;
    logic              frame_clipped;
    logic              block_clipped;

    modport source (output valid, left_out, right_out, pcm_left, pcm_right,
                    frame_clipped, block_clipped, input ready);
    modport sink   (input valid, left_out, right_out, pcm_left, pcm_right,
                    frame_clipped, block_clipped, output ready);
endinterface

`default_nettype wire

// ----- rtl/stereo_peaking_eq_biquad_limiter_core.sv -----
// ============================================================================
// stereo_peaking_eq_biquad_limiter_core
// Stereo biquad EQ section with limiter, 16-bit PCM output and clip flags.
// ============================================================================
// Each channel has its own lane: a transposed direct form II biquad with
// shared Q3.28 coefficients, a clamp to plus or minus 4, a limiter to plus or
// minus 1 and rounding to 16-bit PCM. A frame's result is registered after the
// steps MX, Y, AY, ACC and COMMIT (COMMIT waits for a free output register),
// and the next frame is taken in the cycle after the result is registered, so
// no new frame is taken before the last is finished. The rate is set by the
// feedback path: y must be formed from b0*x and the first delay before a1*y
// and a2*y can be multiplied, and those 32-by-48-bit products are built from
// two 24-bit halves of y and summed in a later cycle. A finished result waits
// in the output register while the next frame is already being processed. The
// user must see coefficients written only while idle; the core does not check.
// ============================================================================
`default_nettype none

module stereo_peaking_eq_biquad_limiter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    speq_frame_if.sink                           i_frame,
    speq_result_if.source                        o_result,
    input  logic                                 i_cfg_we,
    input  logic [speq_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [speq_pkg::COEF_BITS-1:0]       i_cfg_data
);
    import speq_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    logic       r_last;
    t_lane_ctrl ctrl;
    t_coefs     coefs;
    logic       out_free;
    t_sample    lane_x   [LANES];
    t_lane_res  lane_res [LANES];

    speq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (coefs)
    );

    assign lane_x[0]       = i_frame.left_in;
    assign lane_x[LANES-1] = i_frame.right_in;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        speq_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_coefs (coefs),
            .i_x     (lane_x[g]),
            .o_res   (lane_res[g])
        );
    end

    speq_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (ctrl.commit),
        .i_last   (r_last),
        .i_res    (lane_res),
        .o_free   (out_free),
        .o_result (o_result)
    );

    assign i_frame.ready = (r_state == SEQ_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_last <= i_frame.last_in_block;
        end
    end

    always_comb begin
        n_state = r_state;
        ctrl    = '0;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_frame.valid) begin
                    ctrl.load = 1'b1;
                    n_state   = SEQ_MX;
                end
            end
            SEQ_MX: begin
                ctrl.mul_x = 1'b1;
                n_state    = SEQ_Y;
            end
            SEQ_Y: begin
                ctrl.sum_y = 1'b1;
                n_state    = SEQ_AY;
            end
            SEQ_AY: begin
                ctrl.mul_y = 1'b1;
                n_state    = SEQ_ACC;
            end
            SEQ_ACC: begin
                ctrl.acc = 1'b1;
                n_state  = SEQ_COMMIT;
            end
            SEQ_COMMIT: begin
                if (out_free) begin
                    ctrl.commit = 1'b1;
                    n_state     = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/speq_cfg.sv -----
// ============================================================================
// speq_cfg
// Coefficient and bypass register bank with a plain write port.
// ============================================================================
`default_nettype none

module speq_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [speq_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [speq_pkg::COEF_BITS-1:0]       i_cfg_data,
    output speq_pkg::t_coefs                     o_coefs
);
    import speq_pkg::*;

    t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0     <= B0_RESET;
            r_coefs.b1     <= '0;
            r_coefs.b2     <= '0;
            r_coefs.a1     <= '0;
            r_coefs.a2     <= '0;
            r_coefs.bypass <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_B0:     r_coefs.b0     <= i_cfg_data;
                CFG_B1:     r_coefs.b1     <= i_cfg_data;
                CFG_B2:     r_coefs.b2     <= i_cfg_data;
                CFG_A1:     r_coefs.a1     <= i_cfg_data;
                CFG_A2:     r_coefs.a2     <= i_cfg_data;
                CFG_BYPASS: r_coefs.bypass <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// ----- rtl/speq_lane.sv -----
// ============================================================================
// speq_lane
// One channel: transposed direct form II biquad, output clamp, limiter and
// PCM rounding, stepped by the shared sequencer.
// ============================================================================
`default_nettype none

module speq_lane (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  speq_pkg::t_lane_ctrl   i_ctrl,
    input  speq_pkg::t_coefs       i_coefs,
    input  speq_pkg::t_sample      i_x,
    output speq_pkg::t_lane_res    o_res
);
    import speq_pkg::*;

    t_sample r_x;
    t_state  r_d1;
    t_state  r_d2;
    t_state  r_pb0;
    t_state  r_pb1;
    t_state  r_pb2;
    t_state  r_y;
    t_phi    r_pa1_hi;
    t_phi    r_pa2_hi;
    t_plo    r_pa1_lo;
    t_plo    r_pa2_lo;
    t_sample r_yq;
    t_state  r_a1y;
    t_state  r_a2y;
    t_pp     r_pp;
    logic    r_clip;
    t_pcm    r_pcm;
    t_sample r_sample;

    t_px                      px0;
    t_px                      px1;
    t_px                      px2;
    logic signed [YHI_BITS-1:0] y_hi;
    logic signed [YLO_BITS:0]   y_lo;
    t_phi                     phi1;
    t_phi                     phi2;
    t_plo                     plo1;
    t_plo                     plo2;
    t_state                   y_clamp;
    logic signed [31:0]       y_round;
    t_sample                  yq;
    t_py                      py1;
    t_py                      py2;
    logic                     clip;
    t_sample                  s_lim;
    t_pp                      pp;
    logic signed [PP_BITS-FS_BITS-1:0] q;
    logic [FS_BITS-1:0]       rem;
    logic                     round_up;
    logic signed [PP_BITS-FS_BITS-1:0] q_r;
    t_state                   n_d1;
    t_state                   n_d2;

    always_comb begin
        px0 = i_coefs.b0 * r_x;
        px1 = i_coefs.b1 * r_x;
        px2 = i_coefs.b2 * r_x;

        y_hi = r_y[STATE_BITS-1:YLO_BITS];
        y_lo = $signed({1'b0, r_y[YLO_BITS-1:0]});
        phi1 = i_coefs.a1 * y_hi;
        phi2 = i_coefs.a2 * y_hi;
        plo1 = i_coefs.a1 * y_lo;
        plo2 = i_coefs.a2 * y_lo;

        if (r_y > LIM4) begin
            y_clamp = LIM4;
        end else if (r_y < -LIM4) begin
            y_clamp = -LIM4;
        end else begin
            y_clamp = r_y;
        end
        y_round = y_clamp[31:0] + 32'sd128;
        yq      = i_coefs.bypass ? r_x : y_round[31:SHO];

        py1 = (t_py'(r_pa1_hi) <<< YLO_BITS) + t_py'(r_pa1_lo);
        py2 = (t_py'(r_pa2_hi) <<< YLO_BITS) + t_py'(r_pa2_lo);

        clip = (r_yq > PCM_ONE) || (r_yq < -PCM_ONE);
        if (r_yq > PCM_ONE) begin
            s_lim = PCM_ONE;
        end else if (r_yq < -PCM_ONE) begin
            s_lim = -PCM_ONE;
        end else begin
            s_lim = r_yq;
        end
        pp = s_lim * PCM_SCALE;

        q        = r_pp[PP_BITS-1:FS_BITS];
        rem      = r_pp[FS_BITS-1:0];
        round_up = (rem > (FS_BITS'(1) << (FS_BITS - 1)))
                || ((rem == (FS_BITS'(1) << (FS_BITS - 1))) && q[0]);
        q_r      = q + (PP_BITS - FS_BITS)'(round_up);

        n_d1 = f_sat(t_wide'(r_pb1) - t_wide'(r_a1y) + t_wide'(r_d2));
        n_d2 = f_sat(t_wide'(r_pb2) - t_wide'(r_a2y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctrl.commit && !i_coefs.bypass) begin
            r_d1 <= n_d1;
            r_d2 <= n_d2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_x;
        end
        if (i_ctrl.mul_x) begin
            r_pb0 <= f_round_px(px0);
            r_pb1 <= f_round_px(px1);
            r_pb2 <= f_round_px(px2);
        end
        if (i_ctrl.sum_y) begin
            r_y <= f_sat(t_wide'(r_pb0) + t_wide'(r_d1));
        end
        if (i_ctrl.mul_y) begin
            r_pa1_hi <= phi1;
            r_pa2_hi <= phi2;
            r_pa1_lo <= plo1;
            r_pa2_lo <= plo2;
            r_yq     <= yq;
        end
        if (i_ctrl.acc) begin
            r_a1y  <= f_round_py(py1);
            r_a2y  <= f_round_py(py2);
            r_pp   <= pp;
            r_clip <= clip;
        end
        if (i_ctrl.commit) begin
            r_pcm    <= q_r[PCM_BITS-1:0];
            r_sample <= r_yq;
        end
    end

    assign o_res.sample = r_sample;
    assign o_res.pcm    = r_pcm;
    assign o_res.clip   = r_clip;

endmodule

`default_nettype wire

// ----- rtl/speq_merge.sv -----
// ============================================================================
// speq_merge
// Combines the lane results into one output transfer and keeps the sticky
// block clip flag.
// ============================================================================
`default_nettype none

module speq_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_commit,
    input  logic                  i_last,
    input  speq_pkg::t_lane_res   i_res [speq_pkg::LANES],
    output logic                  o_free,
    speq_result_if.source         o_result
);
    import speq_pkg::*;

    logic r_valid;
    logic r_clip_seen;
    logic r_frame_clip;
    logic r_block_clip;
    logic frame_clip;
    logic block_clip;

    always_comb begin
        frame_clip = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            frame_clip = frame_clip | i_res[i].clip;
        end
        block_clip = r_clip_seen | frame_clip;
    end

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_clip_seen <= 1'b0;
        end else if (i_commit) begin
            r_valid     <= 1'b1;
            r_clip_seen <= i_last ? 1'b0 : block_clip;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_frame_clip <= frame_clip;
            r_block_clip <= block_clip;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.left_out      = i_res[0].sample;
    assign o_result.right_out     = i_res[LANES-1].sample;
    assign o_result.pcm_left      = i_res[0].pcm;
    assign o_result.pcm_right     = i_res[LANES-1].pcm;
    assign o_result.frame_clipped = r_frame_clip;
    assign o_result.block_clipped = r_block_clip;

endmodule

`default_nettype wire

// ----- bench/speq_result_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// speq_result_checker
// Watches the frame, result and register ports of the stereo EQ core, works
// out the expected result of every accepted frame and compares each result
// transfer with the oldest expectation. It reports how many frames are still
// awaiting their result and how many mismatches it has seen.
// ============================================================================

module speq_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    speq_frame_if                             i_frame,
    speq_result_if                            i_result,
    input  logic                              i_cfg_we,
    input  logic [speq_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [speq_pkg::COEF_BITS-1:0]    i_cfg_data,
    output int                                o_pending,
    output int                                o_mismatches
);
    import speq_pkg::*;

    localparam int FRAC_S = SAMPLE_BITS - 4;
    localparam int FRAC_C = COEF_BITS - 4;
    localparam int FRAC_D = FRAC_S + 8;
    localparam int SH_X   = FRAC_C + FRAC_S - FRAC_D;
    localparam int SH_OUT = FRAC_D - FRAC_S;
    localparam int REPORT_LIMIT = 10;

    typedef logic signed [STATE_BITS-1:0] t_delay;
    typedef logic signed [127:0]          t_acc;

    localparam t_acc   ACC_TOP   = (128'sd1 <<< (STATE_BITS - 1)) - 128'sd1;
    localparam t_acc   ACC_BOT   = -(128'sd1 <<< (STATE_BITS - 1));
    localparam t_delay Y_LIMIT   = t_delay'(4) <<< FRAC_D;
    localparam t_delay Y_ROUND   = t_delay'(1) <<< (SH_OUT - 1);
    localparam t_coef  TAP_UNITY = t_coef'(1) <<< FRAC_C;
    localparam longint UNIT      = longint'(1) <<< FRAC_S;
    localparam longint PCM_HALF  = longint'(1) <<< (FRAC_S - 1);
    localparam longint PCM_FULL  = 32767;

    typedef struct packed {
        t_sample left;
        t_sample right;
        t_pcm    pcm_l;
        t_pcm    pcm_r;
        logic    frame_clip;
        logic    block_clip;
    } t_frame_result;

    t_coef          tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
    logic           bypass_on;
    t_delay         lane_z1 [2];
    t_delay         lane_z2 [2];
    logic           clip_run;
    t_frame_result  predicted_outputs [$];

    function automatic t_delay saturate_state(input t_acc v);
        if (v > ACC_TOP) begin
            return ACC_TOP[STATE_BITS-1:0];
        end
        if (v < ACC_BOT) begin
            return ACC_BOT[STATE_BITS-1:0];
        end
        return v[STATE_BITS-1:0];
    endfunction

    // Product scaled down by 2^sh, rounded half away from zero, then saturated.
    function automatic t_delay scale_product(input longint a, input longint b, input int sh);
        t_acc         prod;
        logic [127:0] mag;
        logic         neg;
        prod = a * b;
        neg  = prod < 0;
        mag  = neg ? -prod : prod;
        mag  = (mag + (128'd1 << (sh - 1))) >> sh;
        if (mag > (128'd1 << (STATE_BITS - 1))) begin
            mag = 128'd1 << (STATE_BITS - 1);
        end
        prod = $signed(mag);
        if (neg) begin
            prod = -prod;
        end
        return saturate_state(prod);
    endfunction

    function automatic t_sample filter_lane(input t_sample x, input t_delay z1, input t_delay z2,
                                            output t_delay nz1, output t_delay nz2);
        t_acc   acc;
        t_delay y;
        acc = scale_product(tap_b0, x, SH_X);
        acc = acc + z1;
        y   = saturate_state(acc);
        acc = scale_product(tap_b1, x, SH_X);
        acc = acc - scale_product(tap_a1, y, FRAC_C);
        acc = acc + z2;
        nz1 = saturate_state(acc);
        acc = scale_product(tap_b2, x, SH_X);
        acc = acc - scale_product(tap_a2, y, FRAC_C);
        nz2 = saturate_state(acc);
        if (y > Y_LIMIT) begin
            y = Y_LIMIT;
        end else if (y < -Y_LIMIT) begin
            y = -Y_LIMIT;
        end
        y = (y + Y_ROUND) >>> SH_OUT;
        return t_sample'(y);
    endfunction

    // Hard limit to plus or minus one, then scale to PCM with ties to even.
    function automatic t_pcm limit_to_pcm(input t_sample s, output logic clip);
        longint v;
        longint q;
        longint rem;
        v    = s;
        clip = (v > UNIT) || (v < -UNIT);
        if (v > UNIT) begin
            v = UNIT;
        end else if (v < -UNIT) begin
            v = -UNIT;
        end
        v   = v * PCM_FULL;
        q   = v >>> FRAC_S;
        rem = v - (q <<< FRAC_S);
        if (rem > PCM_HALF || (rem == PCM_HALF && q[0])) begin
            q = q + 1;
        end
        return t_pcm'(q);
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        t_sample       lane_x [2];
        t_sample       lane_y [2];
        t_pcm          lane_pcm [2];
        logic          lane_clip [2];
        t_delay        nz1;
        t_delay        nz2;
        if (!i_rst_n) begin
            tap_b0       = TAP_UNITY;
            tap_b1       = '0;
            tap_b2       = '0;
            tap_a1       = '0;
            tap_a2       = '0;
            bypass_on    = 1'b1;
            lane_z1      = '{default: '0};
            lane_z2      = '{default: '0};
            clip_run     = 1'b0;
            predicted_outputs.delete();
            o_pending    = 0;
            o_mismatches = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = '{i_result.left_out, i_result.right_out, i_result.pcm_left,
                        i_result.pcm_right, i_result.frame_clipped, i_result.block_clipped};
                if (predicted_outputs.size() == 0) begin
                    if (o_mismatches < REPORT_LIMIT) begin
                        $display("%0t: result transfer with no frame outstanding", $realtime);
                    end
                    o_mismatches++;
                end else begin
                    want = predicted_outputs.pop_front();
                    o_pending--;
                    if (got !== want) begin
                        if (o_mismatches < REPORT_LIMIT) begin
                            $display("%0t: expected L=%0d R=%0d PL=%0d PR=%0d FC=%0b BC=%0b",
                                     $realtime, want.left, want.right, want.pcm_l,
                                     want.pcm_r, want.frame_clip, want.block_clip);
                            $display("%0t: actual   L=%0d R=%0d PL=%0d PR=%0d FC=%0b BC=%0b",
                                     $realtime, got.left, got.right, got.pcm_l,
                                     got.pcm_r, got.frame_clip, got.block_clip);
                        end
                        o_mismatches++;
                    end
                end
            end
            if (i_frame.valid && i_frame.ready) begin
                lane_x[0] = i_frame.left_in;
                lane_x[1] = i_frame.right_in;
                for (int ch = 0; ch < 2; ch++) begin
                    if (bypass_on) begin
                        lane_y[ch] = lane_x[ch];
                    end else begin
                        lane_y[ch] = filter_lane(lane_x[ch], lane_z1[ch], lane_z2[ch], nz1, nz2);
                        lane_z1[ch] = nz1;
                        lane_z2[ch] = nz2;
                    end
                    lane_pcm[ch] = limit_to_pcm(lane_y[ch], lane_clip[ch]);
                end
                want.left       = lane_y[0];
                want.right      = lane_y[1];
                want.pcm_l      = lane_pcm[0];
                want.pcm_r      = lane_pcm[1];
                want.frame_clip = lane_clip[0] | lane_clip[1];
                clip_run        = clip_run | want.frame_clip;
                want.block_clip = clip_run;
                if (i_frame.last_in_block) begin
                    clip_run = 1'b0;
                end
                predicted_outputs = {predicted_outputs, want};
                o_pending++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_B0: begin
                        tap_b0 = i_cfg_data;
                    end
                    CFG_B1: begin
                        tap_b1 = i_cfg_data;
                    end
                    CFG_B2: begin
                        tap_b2 = i_cfg_data;
                    end
                    CFG_A1: begin
                        tap_a1 = i_cfg_data;
                    end
                    CFG_A2: begin
                        tap_a2 = i_cfg_data;
                    end
                    CFG_BYPASS: begin
                        bypass_on = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus and verdict for the stereo peaking EQ biquad limiter core.
// ============================================================================
// A short directed run covers the sample extremes, the limiter edges, PCM
// rounding ties, the clamp to plus or minus four and saturating coefficients.
// Random phases then follow, each with its own coefficient setting, sending
// blocks of random frames under bursty input and a stalling output.
// ============================================================================

module tb_top;
    import speq_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int PHASE_FRAMES    = 102;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    localparam t_sample S_MAX  = 24'sh7FFFFF;
    localparam t_sample S_MIN  = 24'sh800000;
    localparam t_sample S_ONE  = 24'sh100000;
    localparam t_sample S_HALF = 24'sh080000;
    localparam t_sample S_FOUR = 24'sh400000;
    localparam t_coef   C_MAX  = 32'sh7FFFFFFF;
    localparam t_coef   C_MIN  = 32'sh80000000;
    localparam t_coef   C_UNIT = 32'sh10000000;

    typedef enum int {
        SET_BYPASS,
        SET_UNITY,
        SET_PEAK,
        SET_FLOOR,
        SET_STABLE,
        SET_WILD
    } t_setting;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [COEF_BITS-1:0]    cfg_data;
    int                      pending;
    int                      mismatches;
    int                      burst_left;
    int                      block_left;
    bit                      hold_req;

    speq_frame_if  frame_ch ();
    speq_result_if result_ch ();

    stereo_peaking_eq_biquad_limiter_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_frame    (frame_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    speq_result_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_frame      (frame_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    initial begin
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    // The result side stalls in random modes; once on request it holds off
    // for a long stretch so that the core backs up into its input.
    initial begin
        int hold_left;
        int rx_mode;
        int rx_mode_left;
        bit hold_done;
        hold_left        = 0;
        rx_mode          = 0;
        rx_mode_left     = 0;
        hold_done        = 1'b0;
        result_ch.ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done       = 1'b1;
                hold_left       = HOLD_OFF_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(20, 80);
                end
                rx_mode_left--;
                case (rx_mode)
                    0: begin
                        result_ch.ready <= 1'b1;
                    end
                    1: begin
                        result_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        result_ch.ready <= ($urandom_range(0, 7) != 0);
                    end
                    default: begin
                        result_ch.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_frame(input t_sample left, input t_sample right, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                frame_ch.valid         <= 1'b0;
                frame_ch.left_in       <= t_sample'($urandom);
                frame_ch.right_in      <= t_sample'($urandom);
                frame_ch.last_in_block <= 1'($urandom_range(0, 1));
            end
        end
        burst_left--;
        @(negedge clk);
        frame_ch.valid         <= 1'b1;
        frame_ch.left_in       <= left;
        frame_ch.right_in      <= right;
        frame_ch.last_in_block <= last;
        do begin
            @(posedge clk);
        end while (frame_ch.ready !== 1'b1);
    endtask

    function automatic logic next_last();
        if (block_left == 0) begin
            block_left = $urandom_range(1, 16);
        end
        block_left--;
        return block_left == 0;
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        case ($urandom_range(0, 9))
            0: begin
                s = t_sample'($urandom);
            end
            1: begin
                case ($urandom_range(0, 5))
                    0: s = S_MAX;
                    1: s = S_MIN;
                    2: s = S_ONE;
                    3: s = -S_ONE;
                    4: s = S_ONE + 24'sd1;
                    default: s = -S_ONE - 24'sd1;
                endcase
            end
            2: begin
                s = t_sample'(int'($urandom_range(0, 8388608)) - 4194304);
            end
            default: begin
                s = t_sample'(int'($urandom_range(0, 2621440)) - 1310720);
            end
        endcase
        return s;
    endfunction

    task automatic apply_setting(input t_setting kind);
        logic [COEF_BITS-1:0] taps [5];
        int unsigned          a2_mag;
        int unsigned          a1_span;
        case (kind)
            SET_UNITY: begin
                taps = '{C_UNIT, '0, '0, '0, '0};
            end
            SET_PEAK: begin
                taps = '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX};
            end
            SET_FLOOR: begin
                taps = '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN};
            end
            SET_STABLE: begin
                for (int i = 0; i < 3; i++) begin
                    taps[i] = $urandom_range(0, 536870912) - 32'd268435456;
                end
                a2_mag  = $urandom_range(0, 241591910);
                a1_span = a2_mag + 32'd268435456;
                a1_span = a1_span - a1_span / 16;
                taps[3] = $urandom_range(0, 2 * a1_span) - a1_span;
                taps[4] = a2_mag;
            end
            default: begin
                for (int i = 0; i < 5; i++) begin
                    taps[i] = $urandom;
                end
            end
        endcase
        write_reg(CFG_B0, taps[0]);
        write_reg(CFG_B1, taps[1]);
        write_reg(CFG_B2, taps[2]);
        write_reg(CFG_A1, taps[3]);
        write_reg(CFG_A2, taps[4]);
        write_reg(CFG_BYPASS, {31'($urandom), kind == SET_BYPASS});
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    endtask

    initial begin
        t_setting plan [12];
        plan = '{SET_STABLE, SET_WILD, SET_UNITY, SET_BYPASS, SET_STABLE, SET_PEAK,
                 SET_STABLE, SET_FLOOR, SET_WILD, SET_STABLE, SET_BYPASS, SET_STABLE};
        burst_left             = 0;
        block_left             = 0;
        hold_req               = 1'b0;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = '0;
        cfg_data               = '0;
        frame_ch.valid         = 1'b0;
        frame_ch.left_in       = '0;
        frame_ch.right_in      = '0;
        frame_ch.last_in_block = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting passes samples straight to the limiter.
        send_frame(S_MAX, S_MIN, 1'b0);
        send_frame(S_MIN, S_MAX, 1'b0);
        send_frame(S_ONE, -S_ONE, 1'b0);
        send_frame(S_ONE + 24'sd1, -S_ONE - 24'sd1, 1'b1);
        send_frame(S_HALF, -S_HALF, 1'b1);
        send_frame(24'sd1, -24'sd1, 1'b0);
        send_frame(S_ONE - 24'sd1, 24'sh555555, 1'b0);
        send_frame(24'shAAAAAA, 24'sd0, 1'b1);
        send_frame(24'sd0, 24'sd0, 1'b0);
        wait_idle();

        // Unity section: large inputs hit the clamp to plus or minus four.
        write_reg(CFG_BYPASS, '0);
        send_frame(S_MAX, S_MIN, 1'b0);
        send_frame(S_FOUR, -S_FOUR, 1'b0);
        send_frame(S_ONE, -S_ONE, 1'b1);
        send_frame(S_HALF, 24'sd3, 1'b0);
        wait_idle();

        apply_setting(SET_PEAK);
        send_frame(S_MAX, S_MIN, 1'b0);
        send_frame(S_MIN, S_MAX, 1'b0);
        send_frame(S_ONE, S_ONE, 1'b0);
        send_frame(24'sd0, 24'sd0, 1'b1);
        send_frame(24'sd1, -24'sd1, 1'b0);
        send_frame(24'sd0, 24'sd0, 1'b0);
        wait_idle();

        apply_setting(SET_FLOOR);
        send_frame(S_MAX, S_MAX, 1'b0);
        send_frame(S_MIN, S_MIN, 1'b1);
        send_frame(24'sd0, 24'sd0, 1'b0);

        for (int p = 0; p < 12; p++) begin
            wait_idle();
            apply_setting(plan[p]);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_FRAMES) begin
                send_frame(rand_sample(), rand_sample(), next_last());
            end
        end
        wait_idle();

        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
